// File: hw/rtl/fdiv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdiv_pkg
// Shared types and constants for the FDIV.D execution block.
// ----------------------------------------------------------------------------
package fdiv_pkg;

  localparam int FDIV_REG_COUNT = 32;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EXEC = 1'b1;

  localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
  localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
  localparam logic signed [12:0] EXP_BIAS = 13'sd1023;
  localparam logic signed [12:0] EXP_OVF = 13'sd2047;
  localparam logic signed [12:0] EXP_FLUSH = -13'sd55;
  localparam logic [5:0] QUO_LAST = 6'd54;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_UNPACK,
    ST_NORM,
    ST_PREP,
    ST_DIV,
    ST_DENORM,
    ST_ROUND,
    ST_FIN
  } fdiv_state_t;

endpackage

// File: hw/rtl/fdiv_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdiv_in_if / fdiv_out_if
// Valid/ready channels for instruction beats and result beats.
// ----------------------------------------------------------------------------
interface fdiv_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] instr;
  logic [4:0]  reg_index;
  logic [63:0] write_value;
  modport source (output valid, cmd, instr, reg_index, write_value, input ready);
  modport sink (input valid, cmd, instr, reg_index, write_value, output ready);
endinterface

interface fdiv_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] quotient;
  logic [4:0]  dest_reg;
  modport source (output valid, quotient, dest_reg, input ready);
  modport sink (input valid, quotient, dest_reg, output ready);
endinterface

// File: hw/rtl/fp64_divide_instruction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp64_divide_instruction
// FDIV.D unit: register file loads and binary64 division, round to nearest even.
// ----------------------------------------------------------------------------
//  channel  | dir | beat
//  in_ch    | in  | cmd, instr, reg_index, write_value
//  out_ch   | out | quotient, dest_reg (one per execute beat)
//
//  A load beat writes the register file as it is accepted. An execute beat
//  reads both registers; special operands go straight to write-back. Others
//  normalize subnormal operands one bit per cycle, take 55 quotient bits of
//  the shared restoring subtract one per cycle, shift or flush a subnormal
//  result and round it. Reset is synchronous and clears the register file.
//  Results wait in an output register; a full one stalls the next write-back.
// ----------------------------------------------------------------------------
module fp64_divide_instruction
  import fdiv_pkg::*;
#(
  parameter int REG_COUNT = FDIV_REG_COUNT,
  localparam int AW = $clog2(REG_COUNT)
) (
  input logic         clk,
  input logic         rst_n,
  fdiv_in_if.sink     in_ch,
  fdiv_out_if.source  out_ch
);

  fdiv_state_t state_r, state_nxt;

  logic [AW-1:0]    rd_r, rs1_r, rs2_r;
  logic [63:0]      a_r;
  logic             sign_r;
  logic [53:0]      ma_r;
  logic [52:0]      mb_r;
  logic signed [12:0] ea_r, eb_r, e_r;
  logic [54:0]      rem_r;
  logic [54:0]      q_r;
  logic [55:0]      sig_r;
  logic [5:0]       cnt_r;
  logic [63:0]      res_r;
  logic             out_valid_r;
  logic [63:0]      out_q_r;
  logic [AW-1:0]    out_rd_r;

  logic [AW-1:0]    rf_rd_addr;
  logic [63:0]      rf_rd_data;
  logic             rf_wr_en;
  logic [AW-1:0]    rf_wr_addr;
  logic [63:0]      rf_wr_data;

  logic             in_fire, load_fire, fin_go;

  // unpack
  logic [63:0] b;
  logic [10:0] ea, eb;
  logic [51:0] fa, fb;
  logic        s_x, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, special;
  logic [63:0] special_res;

  // datapath
  logic signed [12:0] e_prep;
  logic        ge;
  logic [54:0] rem_sub, rem_new;
  logic [2:0]  low;
  logic        inc;
  logic [53:0] rsum;
  logic [52:0] mant;
  logic signed [12:0] e_fin;
  logic [63:0] rnd_res;

  fdiv_regfile #(.REG_COUNT(REG_COUNT)) u_rf (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_addr(rf_rd_addr),
    .rd_data(rf_rd_data),
    .wr_en  (rf_wr_en),
    .wr_addr(rf_wr_addr),
    .wr_data(rf_wr_data)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign load_fire   = in_fire && (in_ch.cmd == CMD_LOAD);
  assign fin_go      = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid    = out_valid_r;
  assign out_ch.quotient = out_q_r;
  assign out_ch.dest_reg = 5'(out_rd_r);

  assign rf_rd_addr = (state_r == ST_RD_A) ? rs1_r : rs2_r;
  assign rf_wr_en   = load_fire || fin_go;
  assign rf_wr_addr = load_fire ? in_ch.reg_index[AW-1:0] : rd_r;
  assign rf_wr_data = load_fire ? in_ch.write_value : res_r;

  // special operands
  always_comb begin
    b      = rf_rd_data;
    ea     = a_r[62:52];
    eb     = b[62:52];
    fa     = a_r[51:0];
    fb     = b[51:0];
    s_x    = a_r[63] ^ b[63];
    a_nan  = (ea == EXP_ALL_ONES) && (fa != '0);
    b_nan  = (eb == EXP_ALL_ONES) && (fb != '0);
    a_inf  = (ea == EXP_ALL_ONES);
    b_inf  = (eb == EXP_ALL_ONES);
    a_zero = (ea == '0) && (fa == '0);
    b_zero = (eb == '0) && (fb == '0);
    special     = 1'b1;
    special_res = 64'd0;
    priority if (b == 64'd0) begin
      special_res = 64'd0;
    end else if (a_nan || b_nan) begin
      special_res = CANON_NAN;
    end else if (a_inf) begin
      special_res = b_inf ? CANON_NAN : {s_x, EXP_ALL_ONES, 52'd0};
    end else if (b_inf) begin
      special_res = {s_x, 63'd0};
    end else if (b_zero) begin
      special_res = a_zero ? CANON_NAN : {s_x, EXP_ALL_ONES, 52'd0};
    end else if (a_zero) begin
      special_res = {s_x, 63'd0};
    end else begin
      special = 1'b0;
    end
  end

  // shared subtract, exponent and rounding
  always_comb begin
    e_prep  = ea_r - eb_r + EXP_BIAS;
    ge      = rem_r >= {2'b0, mb_r};
    rem_sub = rem_r - {2'b0, mb_r};
    rem_new = {(ge ? rem_sub[53:0] : rem_r[53:0]), 1'b0};
    low     = sig_r[2:0];
    inc     = (low > 3'd4) || ((low == 3'd4) && sig_r[3]);
    rsum    = {1'b0, sig_r[55:3]} + {53'd0, inc};
    mant    = rsum[53] ? rsum[53:1] : rsum[52:0];
    e_fin   = rsum[53] ? e_r + 13'sd1 : e_r;
    if (e_fin >= EXP_OVF) begin
      rnd_res = {sign_r, EXP_ALL_ONES, 52'd0};
    end else begin
      rnd_res = {sign_r, 11'(e_fin - 13'sd1), 52'd0} + {11'd0, mant};
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire && (in_ch.cmd == CMD_EXEC)) state_nxt = ST_RD_A;
      ST_RD_A:   state_nxt = ST_RD_B;
      ST_RD_B:   state_nxt = ST_UNPACK;
      ST_UNPACK: state_nxt = special ? ST_FIN : ST_NORM;
      ST_NORM:   if (ma_r[52] && mb_r[52]) state_nxt = ST_PREP;
      ST_PREP:   state_nxt = ST_DIV;
      ST_DIV:    if (cnt_r == QUO_LAST) state_nxt = ST_DENORM;
      ST_DENORM: if (e_r > 13'sd0) state_nxt = ST_ROUND;
      ST_ROUND:  state_nxt = ST_FIN;
      ST_FIN:    if (fin_go) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_q_r  <= res_r;
      out_rd_r <= rd_r;
    end
    unique case (state_r)
      ST_IDLE: begin
        rd_r  <= in_ch.instr[7 +: AW];
        rs1_r <= in_ch.instr[15 +: AW];
        rs2_r <= in_ch.instr[20 +: AW];
      end
      ST_RD_B: a_r <= rf_rd_data;
      ST_UNPACK: begin
        res_r  <= special_res;
        sign_r <= s_x;
        ma_r   <= {1'b0, (ea != '0), fa};
        mb_r   <= {(eb != '0), fb};
        ea_r   <= (ea == '0) ? 13'sd1 : $signed({2'b0, ea});
        eb_r   <= (eb == '0) ? 13'sd1 : $signed({2'b0, eb});
      end
      ST_NORM: begin
        if (!ma_r[52]) begin
          ma_r <= {ma_r[52:0], 1'b0};
          ea_r <= ea_r - 13'sd1;
        end
        if (!mb_r[52]) begin
          mb_r <= {mb_r[51:0], 1'b0};
          eb_r <= eb_r - 13'sd1;
        end
      end
      ST_PREP: begin
        cnt_r <= '0;
        if (ma_r < {1'b0, mb_r}) begin
          rem_r <= {ma_r, 1'b0};
          e_r   <= e_prep - 13'sd1;
        end else begin
          rem_r <= {1'b0, ma_r};
          e_r   <= e_prep;
        end
      end
      ST_DIV: begin
        rem_r <= rem_new;
        q_r   <= {q_r[53:0], ge};
        cnt_r <= cnt_r + 6'd1;
        sig_r <= {q_r[53:0], ge, (rem_new != '0)};
      end
      ST_DENORM: begin
        if (e_r <= EXP_FLUSH) begin
          sig_r <= {55'd0, (sig_r != '0)};
          e_r   <= 13'sd1;
        end else if (e_r <= 13'sd0) begin
          sig_r <= {1'b0, sig_r[55:2], sig_r[1] | sig_r[0]};
          e_r   <= e_r + 13'sd1;
        end
      end
      ST_ROUND: res_r <= rnd_res;
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/fdiv_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdiv_regfile
// Register file with registered read and per-entry valid bits cleared on reset.
// ----------------------------------------------------------------------------
module fdiv_regfile
  import fdiv_pkg::*;
#(
  parameter int REG_COUNT = FDIV_REG_COUNT,
  localparam int AW = $clog2(REG_COUNT)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [AW-1:0] rd_addr,
  output logic [63:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [63:0]   wr_data
);

  logic [63:0]          mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;
  logic [63:0]          rd_q_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : 64'd0;

endmodule

// File: test/fdiv_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdiv_tb_if
// Channel interfaces come from the RTL; this file only carries shared
// testbench types for the divide regression.
// ----------------------------------------------------------------------------
package fdiv_tb_pkg;

  typedef struct packed {
    logic [63:0] quotient;
    logic [4:0]  dest_reg;
  } fdiv_result_t;

endpackage

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the FDIV.D unit: register loads and divides with operands
// drawn from special values, subnormals and random patterns. A scoreboard
// keeps a shadow register file and a bit-exact binary64 divider, and compares
// every result beat in order. Some phases idle one or both channels at random.
// ----------------------------------------------------------------------------
module testbench;
  import fdiv_pkg::*;
  import fdiv_tb_pkg::*;

  class fdiv_scoreboard;
    logic [63:0] shadow_regs [32];
    fdiv_result_t pending [$];
    int errors;

    function new();
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      errors = 0;
    endfunction

    function logic [63:0] inf_of(logic s);
      return {s, 11'h7FF, 52'h0};
    endfunction

    function logic [63:0] divide(logic [63:0] a, logic [63:0] b);
      logic sa, sb, s, sticky;
      int ea, eb, e, sh;
      logic [63:0] ma, mb, q, rem, sig, low;
      sa = a[63];
      sb = b[63];
      s = sa ^ sb;
      ea = int'(a[62:52]);
      eb = int'(b[62:52]);
      ma = {12'h0, a[51:0]};
      mb = {12'h0, b[51:0]};
      q = 0;
      if (b == 0) return 64'h0;
      if ((ea == 2047 && ma != 0) || (eb == 2047 && mb != 0)) return CANON_NAN;
      if (ea == 2047) return (eb == 2047) ? CANON_NAN : inf_of(s);
      if (eb == 2047) return {s, 63'h0};
      if (eb == 0 && mb == 0) return (ea == 0 && ma == 0) ? CANON_NAN : inf_of(s);
      if (ea == 0 && ma == 0) return {s, 63'h0};
      if (ea == 0) begin
        ea = 1;
        while (!ma[52]) begin
          ma = ma << 1;
          ea--;
        end
      end else ma[52] = 1'b1;
      if (eb == 0) begin
        eb = 1;
        while (!mb[52]) begin
          mb = mb << 1;
          eb--;
        end
      end else mb[52] = 1'b1;
      e = ea - eb + 1023;
      if (ma < mb) begin
        ma = ma << 1;
        e--;
      end
      rem = ma;
      for (int i = 0; i < 55; i++) begin
        q = q << 1;
        if (rem >= mb) begin
          rem = rem - mb;
          q[0] = 1'b1;
        end
        rem = rem << 1;
      end
      sig = (q << 1) | 64'(rem != 0);
      if (e <= 0) begin
        sh = 1 - e;
        if (sh >= 56) sig = 64'(sig != 0);
        else begin
          sticky = (sig & ((64'd1 << sh) - 1)) != 0;
          sig = (sig >> sh) | 64'(sticky);
        end
        e = 1;
      end
      low = sig & 64'd7;
      sig = sig >> 3;
      if (low > 4 || (low == 4 && sig[0])) sig++;
      if (sig[53]) begin
        sig = sig >> 1;
        e++;
      end
      if (e >= 2047) return inf_of(s);
      return {s, 63'h0} + (64'(e - 1) << 52) + sig;
    endfunction

    function void note_beat(logic cmd, logic [31:0] instr, logic [4:0] idx,
                            logic [63:0] value);
      fdiv_result_t r;
      if (cmd == CMD_LOAD) begin
        shadow_regs[idx] = value;
        return;
      end
      r.quotient = divide(shadow_regs[instr[19:15]], shadow_regs[instr[24:20]]);
      r.dest_reg = instr[11:7];
      shadow_regs[r.dest_reg] = r.quotient;
      pending.push_back(r);
    endfunction

    function void check_result(logic [63:0] quotient, logic [4:0] dest_reg);
      fdiv_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result quotient %h rd %0d", $time, quotient, dest_reg);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (quotient !== exp_r.quotient) begin
        $display("%0t: quotient expected %h actual %h", $time, exp_r.quotient, quotient);
        errors++;
      end
      if (dest_reg !== exp_r.dest_reg) begin
        $display("%0t: rd expected %0d actual %0d", $time, exp_r.dest_reg, dest_reg);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  fdiv_in_if in_ch ();
  fdiv_out_if out_ch ();
  fdiv_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  fp64_divide_instruction dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.cmd = CMD_LOAD;
    in_ch.instr = 0;
    in_ch.reg_index = 0;
    in_ch.write_value = 0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        board.note_beat(in_ch.cmd, in_ch.instr, in_ch.reg_index, in_ch.write_value);
      if (out_ch.valid && out_ch.ready)
        board.check_result(out_ch.quotient, out_ch.dest_reg);
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_beat(logic cmd, logic [31:0] instr, logic [4:0] idx,
                           logic [63:0] value);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.cmd <= cmd;
    in_ch.instr <= instr;
    in_ch.reg_index <= idx;
    in_ch.write_value <= value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic load_reg(logic [4:0] idx, logic [63:0] value);
    send_beat(CMD_LOAD, $urandom, idx, value);
  endtask

  task automatic exec_div(logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2, bit fuzz);
    logic [31:0] w;
    w = fuzz ? $urandom : 32'b0001101_00000_00000_000_00000_1010011;
    w[11:7] = rd;
    w[19:15] = rs1;
    w[24:20] = rs2;
    send_beat(CMD_EXEC, w, 5'($urandom), 64'($urandom));
  endtask

  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(11))
      0: v[62:0] = 0;
      1: v[62:52] = 11'h7FF;
      2: v[62:0] = {11'h7FF, 52'h0};
      3: v[62:52] = 0;
      4: v[62:52] = 11'($urandom_range(2));
      5: v[62:52] = 11'(11'h7FE - $urandom_range(3));
      6: v = 0;
      7: v[62:52] = 11'(1023 + $urandom_range(8) - 4);
      8: v[51:0] = $urandom_range(1) ? 52'h0 : {52{1'b1}};
      default: ;
    endcase
    return v;
  endfunction

  localparam logic [63:0] DIRECTED_VALS [12] = '{
    64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
    64'h7FF8_0000_0000_0001, 64'h0000_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF,
    64'h3FF0_0000_0000_0000, 64'h4008_0000_0000_0000, 64'h000F_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF_FFFF_FFFF, 64'h3FE0_0000_0000_0000};

  task automatic run_phase(int send_pct, int recv_pct, int n);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 45) load_reg(5'($urandom), pick_operand());
      else exec_div(5'($urandom), 5'($urandom), 5'($urandom), $urandom_range(3) == 0);
    end
  endtask

  initial begin
    int waited;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    exec_div(5'd3, 5'd0, 5'd1, 0);
    for (int i = 0; i < 12; i++) load_reg(i[4:0], DIRECTED_VALS[i]);
    load_reg(5'd31, 64'hFFFF_FFFF_FFFF_FFFF);
    exec_div(5'd12, 5'd7, 5'd0, 1);
    exec_div(5'd13, 5'd4, 5'd7, 0);
    exec_div(5'd14, 5'd2, 5'd3, 0);
    exec_div(5'd15, 5'd0, 5'd1, 0);
    exec_div(5'd16, 5'd2, 5'd8, 0);
    exec_div(5'd17, 5'd8, 5'd2, 0);
    exec_div(5'd18, 5'd9, 5'd1, 0);
    exec_div(5'd19, 5'd5, 5'd6, 0);
    exec_div(5'd20, 5'd6, 5'd11, 0);
    exec_div(5'd7, 5'd7, 5'd8, 1);
    exec_div(5'd31, 5'd31, 5'd9, 0);
    run_phase(0, 0, 480);
    run_phase(46, 0, 480);
    run_phase(0, 46, 480);
    run_phase(36, 36, 480);
    in_ch.valid <= 0;
    waited = 0;
    while (board.pending.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("fp64_divide_instruction regression: pass");
    else
      $display("fp64_divide_instruction regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("fp64_divide_instruction regression: fail");
    $finish;
  end
endmodule
